FILE: src/pbt_pkg.sv
// shared types and constants for the projective box transform
package pbt_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int EntWidth   = 32;
  localparam int NumRegs    = 8;
  localparam int RegWidth   = 64;
  localparam int AddrWidth  = 6;
  localparam int ProdWidth  = CoordWidth + EntWidth;
  localparam int AccWidth   = ProdWidth + 2;
  localparam int NshWidth   = AccWidth + FracBits;
  localparam int DsWidth    = AccWidth + CoordWidth - 1;
  localparam int CmpWidth   = ((NshWidth > DsWidth) ? NshWidth : DsWidth) + 1;
  localparam int CntWidth   = $clog2(CoordWidth);
  localparam int BoxWidth   = 6 * CoordWidth;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    coord_t max_z;
    coord_t max_y;
    coord_t max_x;
    coord_t min_z;
    coord_t min_y;
    coord_t min_x;
  } box_t;

  typedef logic [3:0][3:0][EntWidth-1:0] mat_t;

  typedef struct packed {
    logic valid;
    box_t box;
  } head_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MAC,
    BK_DIV,
    BK_OUT
  } back_state_e;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_ABS,
    DV_OVF,
    DV_RUN,
    DV_DONE
  } div_state_e;

endpackage

FILE: src/projective_box_transform.sv
// top level: matrix registers, input queue, corner engine and output register
//
//  channel   | dir | transaction
//  s_axis    | in  | one box, min xyz then max xyz, 32 bits each
//  m_axis    | out | projected bounds, tuser = divide fault
//  apb       | in  | 8 x 64-bit matrix registers at 8*i
//
// each box visits its 8 corners, each a multiply-accumulate pass and a
// division, the 32-step quotient loop dominating.
// boxes queue two deep while the engine works; the output register holds a
// result under backpressure and the engine waits behind it.
// reset loads the identity matrix and empties the queue.
module projective_box_transform (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // min_x, min_y, min_z, max_x, max_y, max_z
  input  logic [pbt_pkg::BoxWidth-1:0]      s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
  output logic [pbt_pkg::BoxWidth-1:0]      m_axis_tdata_o,
  // divide_fault
  output logic                              m_axis_tuser_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pbt_pkg::AddrWidth-1:0]     paddr,
  input  logic [pbt_pkg::RegWidth-1:0]      pwdata,
  output logic [pbt_pkg::RegWidth-1:0]      prdata,
  output logic                              pready
);
  import pbt_pkg::*;

  logic [RegWidth-1:0] regs_q [NumRegs];
  mat_t                mat;
  head_t               head;
  logic                pop, res_valid, res_ready, res_fault;
  box_t                res_box;
  logic                out_valid_q, out_fault_q;
  box_t                out_box_q;

  assign pready = 1'b1;
  assign prdata = regs_q[paddr[AddrWidth-1:3]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= '0;
      regs_q[0] <= RegWidth'(1) << FracBits;
      regs_q[2] <= RegWidth'(1) << (FracBits + 32);
      regs_q[5] <= RegWidth'(1) << FracBits;
      regs_q[7] <= RegWidth'(1) << (FracBits + 32);
    end else if (psel && penable && pwrite && pready) begin
      regs_q[paddr[AddrWidth-1:3]] <= pwdata;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mat[r][0] = regs_q[2*r][31:0];
      mat[r][1] = regs_q[2*r][63:32];
      mat[r][2] = regs_q[2*r+1][31:0];
      mat[r][3] = regs_q[2*r+1][63:32];
    end
  end

  pbt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_box_i   (box_t'(s_axis_tdata_i)),
    .head_o     (head),
    .pop_i      (pop)
  );

  pbt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .mat_i       (mat),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_box_o   (res_box),
    .res_fault_o (res_fault)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_box_q   <= res_box;
      out_fault_q <= res_fault;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_box_q;
  assign m_axis_tuser_o  = out_fault_q;

endmodule

FILE: src/pbt_front.sv
// input side: accepts boxes into a two-entry queue ahead of the engine
module pbt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pbt_pkg::box_t  in_box_i,
  output pbt_pkg::head_t head_o,
  input  logic           pop_i
);
  import pbt_pkg::*;

  box_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (cnt_q != 2'd0);

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_box_i;
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.box   = mem_q[rd_ptr_q];

endmodule

FILE: src/pbt_div.sv
// signed fixed point quotient num * 2^frac / den with saturation, one bit per cycle
module pbt_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [pbt_pkg::AccWidth-1:0]  num_i,
  input  logic signed [pbt_pkg::AccWidth-1:0]  den_i,
  output logic                                 done_o,
  output pbt_pkg::coord_t                      res_o,
  output logic                                 fault_o
);
  import pbt_pkg::*;

  div_state_e            state_q, state_d;
  logic [AccWidth-1:0]   num_q, den_q, nmag_q, dmag_q;
  logic                  nneg_q, neg_q, ovf_q, dzero_q, nzero_q;
  logic [CmpWidth-1:0]   rem_q, ds_q, nsh, thr;
  logic [CoordWidth-1:0] quo_q;
  logic [CntWidth-1:0]   idx_q;
  coord_t                maxv, minv;

  assign maxv = {1'b0, {(CoordWidth-1){1'b1}}};
  assign minv = {1'b1, {(CoordWidth-1){1'b0}}};
  assign nsh  = CmpWidth'({nmag_q, {FracBits{1'b0}}});
  // overflow when n * 2^frac >= (2^(w-1) + neg) * d
  assign thr  = (CmpWidth'(dmag_q) << (CoordWidth-1))
              + (neg_q ? CmpWidth'(dmag_q) : CmpWidth'(0));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DV_IDLE: if (start_i) state_d = DV_ABS;
      DV_ABS:  state_d = DV_OVF;
      DV_OVF:  state_d = DV_RUN;
      DV_RUN:  if (idx_q == '0) state_d = DV_DONE;
      DV_DONE: state_d = DV_IDLE;
      default: state_d = DV_IDLE;
    endcase
  end

  always_comb begin
    done_o  = (state_q == DV_DONE);
    fault_o = dzero_q || ovf_q;
    if (dzero_q)    res_o = nzero_q ? '0 : (nneg_q ? minv : maxv);
    else if (ovf_q) res_o = neg_q ? minv : maxv;
    else            res_o = neg_q ? coord_t'(-quo_q) : coord_t'(quo_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= DV_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DV_IDLE: begin
        num_q <= num_i;
        den_q <= den_i;
      end
      DV_ABS: begin
        nneg_q <= num_q[AccWidth-1];
        neg_q  <= num_q[AccWidth-1] ^ den_q[AccWidth-1];
        nmag_q <= num_q[AccWidth-1] ? -num_q : num_q;
        dmag_q <= den_q[AccWidth-1] ? -den_q : den_q;
      end
      DV_OVF: begin
        ovf_q   <= (nsh >= thr);
        dzero_q <= (dmag_q == '0);
        nzero_q <= (nmag_q == '0);
        rem_q   <= nsh;
        ds_q    <= CmpWidth'(dmag_q) << (CoordWidth-1);
        quo_q   <= '0;
        idx_q   <= CntWidth'(CoordWidth-1);
      end
      DV_RUN: begin
        if (rem_q >= ds_q) begin
          rem_q        <= rem_q - ds_q;
          quo_q[idx_q] <= 1'b1;
        end
        ds_q  <= ds_q >> 1;
        idx_q <= idx_q - CntWidth'(1);
      end
      DV_DONE: ;
      default: ;
    endcase
  end

endmodule

FILE: src/pbt_back.sv
// engine: walks the 8 corners, matrix product then three divisions, min/max reduction
module pbt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pbt_pkg::head_t  head_i,
  output logic            pop_o,
  input  pbt_pkg::mat_t   mat_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output pbt_pkg::box_t   res_box_o,
  output logic            res_fault_o
);
  import pbt_pkg::*;

  back_state_e                 state_q, state_d;
  logic [2:0]                  corner_q, step_q;
  logic signed [ProdWidth-1:0] prod_q [4];
  logic signed [AccWidth-1:0]  acc_q  [4];
  coord_t                      vsel;
  coord_t                      qres [3];
  logic [2:0]                  qdone, qfault;
  logic                        div_start, all_done;
  box_t                        ext_q;
  logic                        fault_q;

  always_comb begin
    unique case (step_q[1:0])
      2'd0:    vsel = corner_q[0] ? head_i.box.max_x : head_i.box.min_x;
      2'd1:    vsel = corner_q[1] ? head_i.box.max_y : head_i.box.min_y;
      2'd2:    vsel = corner_q[2] ? head_i.box.max_z : head_i.box.min_z;
      default: vsel = coord_t'(1) <<< FracBits;
    endcase
  end

  for (genvar a = 0; a < 3; a++) begin : g_div
    pbt_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .num_i   (acc_q[a]),
      .den_i   (acc_q[3]),
      .done_o  (qdone[a]),
      .res_o   (qres[a]),
      .fault_o (qfault[a])
    );
  end

  assign all_done = &qdone;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (head_i.valid) state_d = BK_MAC;
      BK_MAC:  if (step_q == 3'd5) state_d = BK_DIV;
      BK_DIV:  if (all_done) state_d = (corner_q == 3'd7) ? BK_OUT : BK_MAC;
      BK_OUT:  if (res_ready_i) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    div_start   = (state_q == BK_MAC) && (step_q == 3'd5);
    res_valid_o = (state_q == BK_OUT);
    pop_o       = (state_q == BK_OUT) && res_ready_i;
  end

  assign res_box_o   = ext_q;
  assign res_fault_o = fault_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      corner_q <= 3'd0;
      step_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        BK_IDLE: begin
          corner_q <= 3'd0;
          step_q   <= 3'd0;
        end
        BK_MAC:  if (step_q != 3'd5) step_q <= step_q + 3'd1;
        BK_DIV: begin
          if (all_done) begin
            corner_q <= corner_q + 3'd1;
            step_q   <= 3'd0;
          end
        end
        BK_OUT: ;
        default: ;
      endcase
    end
  end

  // products are registered and accumulated in the cycle after they are formed
  always_ff @(posedge clk_i) begin
    if (state_q == BK_MAC) begin
      for (int r = 0; r < 4; r++) begin
        if (step_q < 3'd4)
          prod_q[r] <= $signed(mat_i[r][step_q[1:0]]) * vsel;
        if (step_q == 3'd0)
          acc_q[r] <= '0;
        else if (step_q <= 3'd4)
          acc_q[r] <= acc_q[r] + AccWidth'(prod_q[r]);
      end
    end
    if ((state_q == BK_DIV) && all_done) begin
      fault_q <= (corner_q == 3'd0) ? (|qfault) : (fault_q | (|qfault));
      if (corner_q == 3'd0 || qres[0] < ext_q.min_x) ext_q.min_x <= qres[0];
      if (corner_q == 3'd0 || qres[1] < ext_q.min_y) ext_q.min_y <= qres[1];
      if (corner_q == 3'd0 || qres[2] < ext_q.min_z) ext_q.min_z <= qres[2];
      if (corner_q == 3'd0 || qres[0] > ext_q.max_x) ext_q.max_x <= qres[0];
      if (corner_q == 3'd0 || qres[1] > ext_q.max_y) ext_q.max_y <= qres[1];
      if (corner_q == 3'd0 || qres[2] > ext_q.max_z) ext_q.max_z <= qres[2];
    end
  end

endmodule

FILE: src/pbt_checker.sv
// port-level checks for the projective box transform, bound to the top level
module pbt_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [191:0] m_axis_tdata_o
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped under backpressure");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed under backpressure");

  a_order_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $signed(m_axis_tdata_o[31:0]) <= $signed(m_axis_tdata_o[127:96]))
    else $error("x bounds inverted");

  a_order_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $signed(m_axis_tdata_o[63:32]) <= $signed(m_axis_tdata_o[159:128]))
    else $error("y bounds inverted");

  a_order_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $signed(m_axis_tdata_o[95:64]) <= $signed(m_axis_tdata_o[191:160]))
    else $error("z bounds inverted");

endmodule

bind projective_box_transform pbt_checker u_pbt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

FILE: tb/projective_box_transform_test.sv
// self-checking testbench for the projective box transform
module projective_box_transform_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pbt_pkg::*;

  localparam int RegRow0C01 = 0;
  localparam int RegRow0C23 = 1;
  localparam int RegRow1C01 = 2;
  localparam int RegRow1C23 = 3;
  localparam int RegRow2C01 = 4;
  localparam int RegRow2C23 = 5;
  localparam int RegRow3C01 = 6;
  localparam int RegRow3C23 = 7;
  localparam logic [31:0] One     = 32'h0001_0000;
  localparam logic [31:0] MinusOne = 32'hffff_0000;
  localparam coord_t CoordMax = 32'sh7fff_ffff;
  localparam coord_t CoordMin = 32'sh8000_0000;
  localparam int StallLimit = 5000;
  localparam int DrainCycles = 400;

  typedef struct {
    box_t bounds;
    logic fault;
  } bounds_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  box_t s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  box_t m_axis_tdata_o;
  logic m_axis_tuser_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [RegWidth-1:0] pwdata = '0;
  logic [RegWidth-1:0] prdata;
  logic pready;

  logic [63:0] mat_word [NumRegs];
  bounds_t pending_bounds [$];
  int errors = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;

  projective_box_transform dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o), .m_axis_tuser_o(m_axis_tuser_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic signed [127:0] mat_entry(int row, int col);
    logic [63:0] w;
    logic signed [31:0] e;
    w = mat_word[row * 2 + col / 2];
    e = (col % 2) ? w[63:32] : w[31:0];
    return 128'(e);
  endfunction

  // perspective divide with truncation toward zero and saturation
  function automatic coord_t divide_by_w(logic signed [127:0] num,
                                         logic signed [127:0] w,
                                         inout logic fault);
    logic [127:0] n, d, q;
    logic neg_n, neg_w;
    neg_n = num[127];
    neg_w = w[127];
    n = neg_n ? -num : num;
    d = neg_w ? -w : w;
    if (d == 0) begin
      fault = 1'b1;
      if (n == 0) return '0;
      return neg_n ? CoordMin : CoordMax;
    end
    q = (n << FracBits) / d;
    if (neg_n != neg_w) begin
      if (q > 128'h8000_0000) begin
        fault = 1'b1;
        return CoordMin;
      end
      return coord_t'(-q);
    end
    if (q > 128'h7fff_ffff) begin
      fault = 1'b1;
      return CoordMax;
    end
    return coord_t'(q);
  endfunction

  function automatic bounds_t predict_bounds(box_t b);
    bounds_t res;
    logic signed [127:0] v [4];
    logic signed [127:0] acc [4];
    coord_t p;
    coord_t lo [3];
    coord_t hi [3];
    coord_t mn [3];
    coord_t mx [3];
    res.fault = 1'b0;
    lo[0] = b.min_x; lo[1] = b.min_y; lo[2] = b.min_z;
    hi[0] = b.max_x; hi[1] = b.max_y; hi[2] = b.max_z;
    for (int c = 0; c < 8; c++) begin
      for (int a = 0; a < 3; a++) v[a] = 128'(((c >> a) & 1) ? hi[a] : lo[a]);
      v[3] = 128'sd65536;
      for (int r = 0; r < 4; r++) begin
        acc[r] = '0;
        for (int j = 0; j < 4; j++) acc[r] += mat_entry(r, j) * v[j];
      end
      for (int a = 0; a < 3; a++) begin
        p = divide_by_w(acc[a], acc[3], res.fault);
        if (c == 0 || p < mn[a]) mn[a] = p;
        if (c == 0 || p > mx[a]) mx[a] = p;
      end
    end
    res.bounds.min_x = mn[0]; res.bounds.min_y = mn[1]; res.bounds.min_z = mn[2];
    res.bounds.max_x = mx[0]; res.bounds.max_y = mx[1]; res.bounds.max_z = mx[2];
    return res;
  endfunction

  task automatic write_reg(int idx, logic [63:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= AddrWidth'(idx * 8);
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    mat_word[idx] = value;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_matrix(logic [31:0] m [16]);
    for (int i = 0; i < NumRegs; i++) write_reg(i, {m[2 * i + 1], m[2 * i]});
  endtask

  task automatic load_identity();
    write_reg(RegRow0C01, {32'h0, One});
    write_reg(RegRow0C23, 64'h0);
    write_reg(RegRow1C01, {One, 32'h0});
    write_reg(RegRow1C23, 64'h0);
    write_reg(RegRow2C01, 64'h0);
    write_reg(RegRow2C23, {32'h0, One});
    write_reg(RegRow3C01, 64'h0);
    write_reg(RegRow3C23, {One, 32'h0});
  endtask

  task automatic send_box(box_t b);
    if ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(5)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_bounds.push_back(predict_bounds(b));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_bounds.size() != 0) @(posedge clk_i);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(32'h0010_0000) - 32'h0008_0000);
      2: return coord_t'($urandom_range(32'h0400_0000) - 32'h0200_0000);
      default: return $urandom_range(1) ? CoordMax : CoordMin;
    endcase
  endfunction

  function automatic box_t rand_box();
    box_t b;
    b.min_x = rand_coord(); b.min_y = rand_coord(); b.min_z = rand_coord();
    b.max_x = rand_coord(); b.max_y = rand_coord(); b.max_z = rand_coord();
    return b;
  endfunction

  function automatic logic [31:0] rand_entry(bit full);
    if (full) return $urandom;
    return $urandom_range(32'h0008_0000) - 32'h0004_0000;
  endfunction

  task automatic test_identity_extremes();
    box_t b;
    load_identity();
    send_box('{CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax});
    send_box('{CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin});
    send_box('{CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin});
    // min above max on every axis
    send_box('{CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax});
    send_box('0);
    send_box('{32'sh0002_0000, 32'sh0001_8000, 32'sh0000_0001,
               32'shffff_ffff, 32'shfffe_8000, 32'shfffd_0000});
    b = '{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555,
          32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa};
    send_box(b);
    send_box(~b);
    wait_drained();
  endtask

  task automatic test_divide_faults();
    // zero w row
    write_reg(RegRow3C23, 64'h0);
    send_box('{32'sh0001_0000, 32'sh0, 32'shffff_0000,
               32'sh0002_0000, 32'sh0, 32'sh0003_0000});
    send_box('0);
    wait_drained();
    // tiny w forces quotient saturation
    write_reg(RegRow3C23, {32'h1, 32'h0});
    send_box('{32'sh0100_0000, 32'sh0000_0001, 32'shff00_0000,
               32'sh7000_0000, 32'sh0000_8000, 32'shfff0_0000});
    send_box('{CoordMin, CoordMax, 32'sh0, CoordMax, CoordMin, 32'sh0});
    wait_drained();
    // negative w
    write_reg(RegRow3C23, {MinusOne, 32'h0});
    send_box('{32'sh0003_0000, 32'shfffd_0000, CoordMin,
               32'sh0005_8000, 32'sh0001_0000, CoordMax});
    wait_drained();
    // w = z: division by depth
    write_reg(RegRow3C23, {32'h0, One});
    send_box('{32'sh0001_0000, 32'sh0002_0000, 32'sh0,
               32'sh0004_0000, 32'sh0008_0000, 32'sh0002_0000});
    send_box('{32'shfff0_0000, 32'sh0010_0000, 32'shffff_0000,
               32'sh0010_0000, 32'shfff0_0000, 32'shfffe_0000});
    send_box('{CoordMin, CoordMin, 32'sh0000_0001, CoordMax, CoordMax, CoordMin});
    wait_drained();
  endtask

  task automatic test_random_matrices(int snd_pct, int rcv_pct, int boxes,
                                      bit full_range);
    logic [31:0] m [16];
    sender_idle_pct = snd_pct;
    stall_pct = rcv_pct;
    for (int i = 0; i < 16; i++) m[i] = rand_entry(full_range);
    // keep w mostly positive for the scaled-down matrices
    if (!full_range && $urandom_range(3) != 0) m[15] = One + $urandom_range(32'h0004_0000);
    load_matrix(m);
    for (int k = 0; k < boxes; k++) begin
      send_box(rand_box());
      if (k == boxes / 2) wait_drained();
    end
    wait_drained();
  endtask

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    bounds_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_bounds.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        want = pending_bounds.pop_front();
        if (m_axis_tdata_o.min_x !== want.bounds.min_x) begin
          $error("out_min_x expected %h got %h", want.bounds.min_x, m_axis_tdata_o.min_x);
          errors++;
        end
        if (m_axis_tdata_o.min_y !== want.bounds.min_y) begin
          $error("out_min_y expected %h got %h", want.bounds.min_y, m_axis_tdata_o.min_y);
          errors++;
        end
        if (m_axis_tdata_o.min_z !== want.bounds.min_z) begin
          $error("out_min_z expected %h got %h", want.bounds.min_z, m_axis_tdata_o.min_z);
          errors++;
        end
        if (m_axis_tdata_o.max_x !== want.bounds.max_x) begin
          $error("out_max_x expected %h got %h", want.bounds.max_x, m_axis_tdata_o.max_x);
          errors++;
        end
        if (m_axis_tdata_o.max_y !== want.bounds.max_y) begin
          $error("out_max_y expected %h got %h", want.bounds.max_y, m_axis_tdata_o.max_y);
          errors++;
        end
        if (m_axis_tdata_o.max_z !== want.bounds.max_z) begin
          $error("out_max_z expected %h got %h", want.bounds.max_z, m_axis_tdata_o.max_z);
          errors++;
        end
        if (m_axis_tuser_o !== want.fault) begin
          $error("divide_fault expected %b got %b", want.fault, m_axis_tuser_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
          || (psel && penable)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > StallLimit) begin
        $display("projective_box_transform verification failed");
        $finish;
      end
    end
  end

  initial begin
    mat_word[0] = {32'h0, One};
    mat_word[1] = 64'h0;
    mat_word[2] = {One, 32'h0};
    mat_word[3] = 64'h0;
    mat_word[4] = 64'h0;
    mat_word[5] = {32'h0, One};
    mat_word[6] = 64'h0;
    mat_word[7] = {One, 32'h0};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_identity_extremes();
    test_divide_faults();
    test_random_matrices(0, 0, 150, 1'b0);
    test_random_matrices(54, 0, 150, 1'b0);
    test_random_matrices(0, 54, 150, 1'b1);
    test_random_matrices(20, 20, 150, 1'b0);
    test_random_matrices(0, 0, 150, 1'b1);
    test_random_matrices(20, 20, 150, 1'b0);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_bounds.size() != 0) begin
      $error("%0d expected results never arrived", pending_bounds.size());
      errors++;
    end
    if (errors == 0) begin
      $display("projective_box_transform verification clean");
    end else begin
      $display("projective_box_transform verification failed");
    end
    $finish;
  end

endmodule
